// ----- rtl/sqou_pkg.sv -----
`timescale 1ns / 1ps
package sqou_pkg;

  localparam int DEPTH_DEF   = 32;
  localparam int MAX_RESULTS = 32;
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int STAT_W      = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LIST = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SWAP = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_SHORT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY_LIST = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              do_push;
    logic              do_pop;
    logic              rd_top;
    logic              list_init;
    logic              list_step;
    logic              swap_rd;
    logic              swap_wr_top;
    logic              swap_wr_low;
    logic              emit;
    logic              emit_data;
    logic [STAT_W-1:0] emit_status;
  } sqou_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic too_short;
    logic list_last;
  } sqou_stat_t;

endpackage

// ----- rtl/sqou_ram.sv -----
`timescale 1ns / 1ps
module sqou_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sqou_ctrl.sv -----
`timescale 1ns / 1ps
module sqou_ctrl
  import sqou_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CMD_W-1:0] command,
  input  sqou_stat_t       stat,
  output logic             busy,
  output sqou_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE        = 3'd0;
  localparam logic [2:0] S_PEEK        = 3'd1;
  localparam logic [2:0] S_LIST        = 3'd2;
  localparam logic [2:0] S_SWAP_RD     = 3'd3;
  localparam logic [2:0] S_SWAP_WR_TOP = 3'd4;
  localparam logic [2:0] S_SWAP_WR_LOW = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (command)
            CMD_PUSH: begin
              cmd.emit = 1'b1;
              if (stat.full) begin
                cmd.emit_status = ST_FULL;
              end else begin
                cmd.do_push = 1'b1;
              end
            end
            CMD_LIST: begin
              if (stat.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_EMPTY_LIST;
              end else begin
                cmd.rd_top    = 1'b1;
                cmd.list_init = 1'b1;
                state_nxt     = S_LIST;
              end
            end
            CMD_PEEK: begin
              if (stat.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_EMPTY;
              end else begin
                cmd.rd_top = 1'b1;
                state_nxt  = S_PEEK;
              end
            end
            CMD_POP: begin
              cmd.emit = 1'b1;
              if (stat.empty) begin
                cmd.emit_status = ST_EMPTY;
              end else begin
                cmd.do_pop = 1'b1;
              end
            end
            CMD_SWAP: begin
              if (stat.too_short) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_TOO_SHORT;
              end else begin
                cmd.rd_top = 1'b1;
                state_nxt  = S_SWAP_RD;
              end
            end
            default: begin
              // Unknown commands are dropped without a result.
            end
          endcase
        end
      end
      S_PEEK: begin
        cmd.emit      = 1'b1;
        cmd.emit_data = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_LIST: begin
        cmd.list_step = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_data = 1'b1;
        if (stat.list_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_SWAP_RD: begin
        cmd.swap_rd = 1'b1;
        state_nxt   = S_SWAP_WR_TOP;
      end
      S_SWAP_WR_TOP: begin
        cmd.swap_wr_top = 1'b1;
        state_nxt       = S_SWAP_WR_LOW;
      end
      S_SWAP_WR_LOW: begin
        cmd.swap_wr_low = 1'b1;
        cmd.emit        = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/sqou_dp.sv -----
`timescale 1ns / 1ps
module sqou_dp
  import sqou_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic signed [DATA_W-1:0] push_value,
  input  sqou_cmd_t                cmd,
  output sqou_stat_t               stat,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_value_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_last
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0]  top_r, bot_r, lp_r;
  logic [CNT_W-1:0]  cnt_r, remain_r;
  logic              queue_mode_r;
  logic [DATA_W-1:0] hold_r;

  logic              out_strobe_r, out_valid_r, out_last_r;
  logic [DATA_W-1:0] out_value_r;
  logic [STAT_W-1:0] out_status_r;

  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic [PTR_W-1:0]  low_ptr;
  logic [CNT_W-1:0]  list_n;

  function automatic logic [PTR_W-1:0] ring_up(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_down(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  assign stat.empty     = (cnt_r == '0);
  assign stat.full      = (cnt_r == CNT_W'(DEPTH));
  assign stat.too_short = (cnt_r < CNT_W'(2));
  assign stat.list_last = (remain_r == CNT_W'(1));

  // Entry just below the top, the partner of a swap.
  assign low_ptr = ring_down(top_r);
  assign list_n  = (32'(cnt_r) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : cnt_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = top_r;
    ram_wdata = push_value;
    if (cmd.do_push) begin
      ram_we = 1'b1;
      if (cnt_r == '0) begin
        ram_waddr = top_r;
      end else if (!queue_mode_r) begin
        ram_waddr = ring_up(top_r);
      end else begin
        ram_waddr = ring_down(bot_r);
      end
    end else if (cmd.swap_wr_top) begin
      ram_we    = 1'b1;
      ram_waddr = top_r;
      ram_wdata = ram_rdata;
    end else if (cmd.swap_wr_low) begin
      ram_we    = 1'b1;
      ram_waddr = low_ptr;
      ram_wdata = hold_r;
    end
  end

  assign ram_re    = cmd.rd_top | cmd.swap_rd | (cmd.list_step & ~stat.list_last);
  assign ram_raddr = cmd.rd_top ? top_r : (cmd.swap_rd ? low_ptr : lp_r);

  sqou_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r        <= '0;
      bot_r        <= '0;
      cnt_r        <= '0;
      lp_r         <= '0;
      remain_r     <= '0;
      queue_mode_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        queue_mode_r <= cfg_wr_data;
      end
      if (cmd.do_push) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == '0) begin
          bot_r <= top_r;
        end else if (!queue_mode_r) begin
          top_r <= ring_up(top_r);
        end else begin
          bot_r <= ring_down(bot_r);
        end
      end
      if (cmd.do_pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
        // The last entry leaves the top pointer where it is.
        if (cnt_r != CNT_W'(1)) begin
          top_r <= ring_down(top_r);
        end
      end
      if (cmd.list_init) begin
        lp_r     <= ring_down(top_r);
        remain_r <= list_n;
      end else if (cmd.list_step && !stat.list_last) begin
        lp_r     <= ring_down(lp_r);
        remain_r <= remain_r - CNT_W'(1);
      end
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.swap_rd) begin
      hold_r <= ram_rdata;
    end
    if (cmd.emit) begin
      out_value_r  <= cmd.emit_data ? ram_rdata : '0;
      out_valid_r  <= cmd.emit_data;
      out_status_r <= cmd.emit_status;
      out_last_r   <= cmd.list_step ? stat.list_last : 1'b1;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_value       = out_value_r;
  assign out_value_valid = out_valid_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule

// ----- rtl/stack_queue_opcode_unit.sv -----
`timescale 1ns / 1ps
// Push, pop and rejected requests give their result in the cycle after acceptance; unknown requests give none.
// Peek reads the top entry, then gives it as its result; swap does two reads, then two writes.
// List reads the top entry first, then gives one entry per cycle, the top first.
// Throughput: push and pop one request per cycle; peek, swap and list hold off new requests,
// since busy is high while one of them is in progress and no request is taken while busy.
// Synchronous active-low reset empties the store and clears queue mode; results cannot be stalled.
module stack_queue_opcode_unit
  import sqou_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_push_value,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_value_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_last
);

  sqou_cmd_t  cmd;
  sqou_stat_t stat;

  sqou_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_command),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  sqou_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .push_value      (in_push_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_strobe      (out_strobe),
    .out_value       (out_value),
    .out_value_valid (out_value_valid),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule
